@@ sv/sti_pkg.sv @@
// ----------------------------------------------------------------------------
// sti_pkg - sorted table shared definitions
// request and status codes, entry layout, controller states and the
// command / status bundles between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

  localparam int KEY_W   = 64;
  localparam int PRICE_W = 24;
  localparam int QTY_W   = 20;
  localparam int IDX_W   = 6;   // width of the reported index
  localparam int CNT_W   = 7;   // width of the reported count

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SHIFT,
    S_INS_PUT,
    S_SRCH_ISSUE,
    S_SRCH_CMP,
    S_DEL_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       load;        // capture the input beat
    logic       ins_start;   // ptr = count, read entry below it
    logic       shift_down;  // move read entry one place up, ptr--
    logic       put;         // write new entry at ptr, count++
    logic       srch_init;   // left = 0, right = count - 1
    logic       srch_read;   // latch midpoint and read it
    logic       srch_step;   // narrow the search window
    logic       set_plain;   // result with zero index and payload
    logic [1:0] plain_status;
    logic       set_hit;     // result at the midpoint
    logic       del_start;   // ptr = mid, read the entry above
    logic       shift_up;    // move read entry one place down, ptr++
    logic       dec_count;
    logic       publish;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       cnt_zero;
    logic       gt;          // read key above request key
    logic       eq;
    logic       lt;
    logic       ptr_gt1;
    logic       mid_more;    // an entry sits above the midpoint
    logic       ptr_more;    // an entry sits two above ptr
    logic       lr_ok;       // search window not empty
    logic       out_busy;    // output register held by a stalled beat
  } stat_t;

endpackage

`default_nettype wire

@@ sv/sti_dp.sv @@
// ----------------------------------------------------------------------------
// sti_dp - sorted table datapath
// entry memory, request registers, search window, shift pointer, entry
// count and the result / output registers
// ----------------------------------------------------------------------------
`default_nettype none

module sti_dp #(
  parameter int DEPTH      = 64,
  parameter int NAME_BYTES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sti_pkg::cmd_t              cmd,
  output sti_pkg::stat_t                  stat,
  input  wire logic [1:0]                 in_req,
  input  wire logic [sti_pkg::KEY_W-1:0]  in_key,
  input  wire logic [sti_pkg::PRICE_W-1:0] in_price,
  input  wire logic [sti_pkg::QTY_W-1:0]  in_qty,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [sti_pkg::IDX_W-1:0]       out_index,
  output logic [sti_pkg::PRICE_W-1:0]     out_price,
  output logic [sti_pkg::QTY_W-1:0]       out_qty,
  output logic [sti_pkg::CNT_W-1:0]       out_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 1;
  localparam int SW = IW + 2;
  localparam logic [sti_pkg::KEY_W-1:0] KEY_MASK =
    ~{sti_pkg::KEY_W{1'b0}} << (sti_pkg::KEY_W - 8 * NAME_BYTES);

  sti_pkg::entry_t mem [DEPTH];
  sti_pkg::entry_t rdata;
  sti_pkg::entry_t wdata;
  logic            mem_we;
  logic            mem_re;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   raddr;

  logic [1:0]                   req;
  logic [sti_pkg::KEY_W-1:0]    key;
  logic [sti_pkg::PRICE_W-1:0]  price;
  logic [sti_pkg::QTY_W-1:0]    qty;
  logic [CW-1:0]                count;
  logic [IW-1:0]                ptr;
  logic [IW-1:0]                mid;
  logic signed [SW-1:0]         left;
  logic signed [SW-1:0]         right;
  logic signed [SW-1:0]         mid_calc;

  logic [1:0]                   res_status;
  logic [IW-1:0]                res_index;
  logic [sti_pkg::PRICE_W-1:0]  res_price;
  logic [sti_pkg::QTY_W-1:0]    res_qty;

  logic [IW+sti_pkg::IDX_W-1:0] index_wide;
  logic [CW+sti_pkg::CNT_W-1:0] count_wide;

  assign mid_calc = left + ((right - left) >>> 1);

  // memory port control
  always_comb begin
    mem_re = cmd.ins_start | cmd.shift_down | cmd.srch_read | cmd.del_start | cmd.shift_up;
    mem_we = cmd.shift_down | cmd.put | cmd.shift_up;
    waddr  = ptr;
    wdata  = cmd.put ? sti_pkg::entry_t'{key: key, price: price, qty: qty} : rdata;
    priority if (cmd.ins_start) begin
      raddr = count[IW-1:0] - IW'(1);
    end else if (cmd.shift_down) begin
      raddr = ptr - IW'(2);
    end else if (cmd.srch_read) begin
      raddr = mid_calc[IW-1:0];
    end else if (cmd.del_start) begin
      raddr = mid + IW'(1);
    end else begin
      raddr = ptr + IW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // status to the controller
  always_comb begin
    stat.req      = req;
    stat.full     = (count == CW'(DEPTH));
    stat.cnt_zero = (count == '0);
    stat.gt       = (rdata.key > key);
    stat.eq       = (rdata.key == key);
    stat.lt       = (rdata.key < key);
    stat.ptr_gt1  = (ptr > IW'(1));
    stat.mid_more = ((EW'(mid) + EW'(1)) < EW'(count));
    stat.ptr_more = ((EW'(ptr) + EW'(2)) < EW'(count));
    stat.lr_ok    = (left <= right);
    stat.out_busy = out_valid & ~out_ready;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= in_req;
      key   <= in_key & KEY_MASK;
      price <= in_price;
      qty   <= in_qty;
    end
  end

  // pointer and search window
  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      ptr <= count[IW-1:0];
    end else if (cmd.shift_down) begin
      ptr <= ptr - IW'(1);
    end else if (cmd.del_start) begin
      ptr <= mid;
    end else if (cmd.shift_up) begin
      ptr <= ptr + IW'(1);
    end
    if (cmd.srch_init) begin
      left  <= '0;
      right <= SW'(count) - SW'(1);
    end else if (cmd.srch_step) begin
      if (stat.lt) begin
        left <= SW'(mid) + SW'(1);
      end else begin
        right <= SW'(mid) - SW'(1);
      end
    end
    if (cmd.srch_read) begin
      mid <= mid_calc[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.put) begin
      count <= count + CW'(1);
    end else if (cmd.dec_count) begin
      count <= count - CW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.set_plain) begin
      res_status <= cmd.plain_status;
      res_index  <= '0;
      res_price  <= '0;
      res_qty    <= '0;
    end else if (cmd.put) begin
      res_status <= sti_pkg::ST_OK;
      res_index  <= ptr;
      res_price  <= '0;
      res_qty    <= '0;
    end else if (cmd.set_hit) begin
      res_status <= sti_pkg::ST_OK;
      res_index  <= mid;
      res_price  <= (req == sti_pkg::REQ_LOOKUP) ? rdata.price : '0;
      res_qty    <= (req == sti_pkg::REQ_LOOKUP) ? rdata.qty : '0;
    end
  end

  assign index_wide = {{sti_pkg::IDX_W{1'b0}}, res_index};
  assign count_wide = {{sti_pkg::CNT_W{1'b0}}, count};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status <= res_status;
      out_index  <= index_wide[sti_pkg::IDX_W-1:0];
      out_price  <= res_price;
      out_qty    <= res_qty;
      out_count  <= count_wide[sti_pkg::CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ sv/sti_ctrl.sv @@
// ----------------------------------------------------------------------------
// sti_ctrl - sorted table controller
// sequences insert shifts, binary search steps and delete shifts
// ----------------------------------------------------------------------------
`default_nettype none

module sti_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sti_pkg::stat_t  stat,
  output sti_pkg::cmd_t        cmd
);

  sti_pkg::state_t state;
  sti_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sti_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      sti_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sti_pkg::S_DISPATCH;
        end
      end
      sti_pkg::S_DISPATCH: begin
        unique case (stat.req)
          sti_pkg::REQ_INSERT: begin
            if (stat.full) begin
              cmd.set_plain    = 1'b1;
              cmd.plain_status = sti_pkg::ST_FULL;
              state_next       = sti_pkg::S_FINISH;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = stat.cnt_zero ? sti_pkg::S_INS_PUT : sti_pkg::S_INS_SHIFT;
            end
          end
          sti_pkg::REQ_LOOKUP, sti_pkg::REQ_DELETE: begin
            cmd.srch_init = 1'b1;
            state_next    = sti_pkg::S_SRCH_ISSUE;
          end
          default: begin
            // unused code: empty ok result
            cmd.set_plain    = 1'b1;
            cmd.plain_status = sti_pkg::ST_OK;
            state_next       = sti_pkg::S_FINISH;
          end
        endcase
      end
      sti_pkg::S_INS_SHIFT: begin
        if (stat.gt) begin
          cmd.shift_down = 1'b1;
          state_next     = stat.ptr_gt1 ? sti_pkg::S_INS_SHIFT : sti_pkg::S_INS_PUT;
        end else begin
          cmd.put    = 1'b1;
          state_next = sti_pkg::S_FINISH;
        end
      end
      sti_pkg::S_INS_PUT: begin
        cmd.put    = 1'b1;
        state_next = sti_pkg::S_FINISH;
      end
      sti_pkg::S_SRCH_ISSUE: begin
        if (stat.lr_ok) begin
          cmd.srch_read = 1'b1;
          state_next    = sti_pkg::S_SRCH_CMP;
        end else begin
          cmd.set_plain    = 1'b1;
          cmd.plain_status = sti_pkg::ST_NOT_FOUND;
          state_next       = sti_pkg::S_FINISH;
        end
      end
      sti_pkg::S_SRCH_CMP: begin
        if (stat.eq) begin
          cmd.set_hit = 1'b1;
          if (stat.req == sti_pkg::REQ_DELETE) begin
            if (stat.mid_more) begin
              cmd.del_start = 1'b1;
              state_next    = sti_pkg::S_DEL_SHIFT;
            end else begin
              cmd.dec_count = 1'b1;
              state_next    = sti_pkg::S_FINISH;
            end
          end else begin
            state_next = sti_pkg::S_FINISH;
          end
        end else begin
          cmd.srch_step = 1'b1;
          state_next    = sti_pkg::S_SRCH_ISSUE;
        end
      end
      sti_pkg::S_DEL_SHIFT: begin
        cmd.shift_up = 1'b1;
        if (!stat.ptr_more) begin
          cmd.dec_count = 1'b1;
          state_next    = sti_pkg::S_FINISH;
        end
      end
      sti_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = sti_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sti_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sorted_table_insert_search_delete_core.sv @@
// ----------------------------------------------------------------------------
// sorted_table_insert_search_delete_core - sorted key table with search
// stream front end around the sorted table controller and datapath
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH entries (8-byte big-endian name key, price in
// cents, quantity) in one single-port-write, registered-read memory, sorted
// by key as an unsigned number. Only the leading NAME_BYTES bytes of a key
// take part; lower bytes are cleared on entry. An insert walks down from the
// top of the table, moving one larger entry up per cycle, and lands after any
// equal keys; a full table refuses it with status 2. Lookup and delete run a
// binary search (midpoint left+(right-left)/2); each probe issues its memory
// read in S_SRCH_ISSUE and compares the returned key in S_SRCH_CMP. A delete
// then closes the gap one entry per cycle. One request is worked at a time,
// with log2(DEPTH)+1 probes at most per search. The memory's single write
// port sets the shift rate. The result sits in an output register, so the
// next request is taken while a result still waits to be taken. No clearing
// pass is needed after reset; only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_search_delete_core #(
  parameter int DEPTH      = 64,
  parameter int NAME_BYTES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // request beat
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,  // item_key[63:0], item_price[87:64],
                                           // item_quantity[107:88], zero pad
  input  wire logic [1:0]   s_axis_tuser,  // req_type
  // result beat
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // found_index[5:0], found_price[29:6],
                                           // found_quantity[49:30],
                                           // stored_count[56:50], zero pad
  output logic [1:0]        m_axis_tuser   // status
);

  sti_pkg::cmd_t  cmd;
  sti_pkg::stat_t stat;

  logic [1:0]                  out_status;
  logic [sti_pkg::IDX_W-1:0]   out_index;
  logic [sti_pkg::PRICE_W-1:0] out_price;
  logic [sti_pkg::QTY_W-1:0]   out_qty;
  logic [sti_pkg::CNT_W-1:0]   out_count;

  // sequencer: one request in flight
  sti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memory, search window, result and output registers
  sti_dp #(
    .DEPTH      (DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (s_axis_tuser),
    .in_key     (s_axis_tdata[63:0]),
    .in_price   (s_axis_tdata[87:64]),
    .in_qty     (s_axis_tdata[107:88]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_index  (out_index),
    .out_price  (out_price),
    .out_qty    (out_qty),
    .out_count  (out_count)
  );

  // result beat packing, lowest field first
  assign m_axis_tdata = {7'd0, out_count, out_qty, out_price, out_index};
  assign m_axis_tuser = out_status;

  // memory writes come from at most one source per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.shift_down, cmd.put, cmd.shift_up}))
    else $error("more than one table write source active");

  // a hit is only reported on a matching probe
  a_hit_on_match: assert property (@(posedge clk) disable iff (rst)
    cmd.set_hit |-> stat.eq)
    else $error("hit reported without key match");

  // a new request is not taken while one is being worked
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb - sorted table insert / lookup / delete testbench
// drives request beats into the core with random gaps and result stalls,
// keeps its own sorted table to predict every result beat and compares
// the returned status, index, price, quantity and count field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = 64;
  localparam int TBL_NBYTES  = 8;
  localparam logic [sti_pkg::KEY_W-1:0] KEY_MASK = ~64'd0 << (64 - 8 * TBL_NBYTES);
  localparam logic [1:0] REQ_UNUSED = 2'd3;   // spare code, must be ignored
  localparam int QUIET_LIMIT = 5000;          // cycles with no beat at all
  localparam int DRAIN_CYCLES = 120;          // above the slowest delete

  // one result beat, fields as the core reports them
  typedef struct packed {
    logic [1:0]                  status;
    logic [sti_pkg::IDX_W-1:0]   index;
    logic [sti_pkg::PRICE_W-1:0] price;
    logic [sti_pkg::QTY_W-1:0]   qty;
    logic [sti_pkg::CNT_W-1:0]   count;
  } result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;   // key[63:0], price[87:64], qty[107:88], pad
  logic [1:0]   s_axis_tuser = '0;   // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // index[5:0], price[29:6], qty[49:30],
                                     // count[56:50], pad
  logic [1:0]   m_axis_tuser;        // status

  // shadow copy of the table, in the order the core should hold it
  logic [sti_pkg::KEY_W-1:0]   tbl_key   [TBL_DEPTH];
  logic [sti_pkg::PRICE_W-1:0] tbl_price [TBL_DEPTH];
  logic [sti_pkg::QTY_W-1:0]   tbl_qty   [TBL_DEPTH];
  int                          tbl_count = 0;

  result_t pending_results [$];

  bit idle_on = 1'b1;
  int error_count = 0;
  int n_checked = 0;
  int quiet_cycles = 0;

  // tallies for the closing summary
  int n_insert = 0, n_refused = 0, n_lookup = 0, n_lookup_hit = 0;
  int n_delete = 0, n_delete_hit = 0, n_unused = 0, peak_fill = 0;

  sorted_table_insert_search_delete_core #(
    .DEPTH      (TBL_DEPTH),
    .NAME_BYTES (TBL_NBYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // table predictor
  // ------------------------------------------------------------------------

  // binary search with midpoint left+(right-left)/2, -1 when absent
  function automatic int find_key(input logic [sti_pkg::KEY_W-1:0] key);
    int left;
    int right;
    int mid;
    left  = 0;
    right = tbl_count - 1;
    while (left <= right) begin
      mid = left + (right - left) / 2;
      if (tbl_key[mid] == key) return mid;
      if (tbl_key[mid] < key) left = mid + 1;
      else right = mid - 1;
    end
    return -1;
  endfunction

  // applies one accepted request to the shadow table, returns its result
  function automatic result_t table_apply(input logic [1:0] req,
                                          input logic [sti_pkg::KEY_W-1:0] raw_key,
                                          input logic [sti_pkg::PRICE_W-1:0] price,
                                          input logic [sti_pkg::QTY_W-1:0] qty);
    result_t r;
    logic [sti_pkg::KEY_W-1:0] key;
    int j;
    int pos;
    r   = '0;
    key = raw_key & KEY_MASK;
    r.status = sti_pkg::ST_OK;
    case (req)
      sti_pkg::REQ_INSERT: begin
        n_insert++;
        if (tbl_count >= TBL_DEPTH) begin
          r.status = sti_pkg::ST_FULL;
          n_refused++;
        end else begin
          // walk down past every larger key so equal keys keep arrival order
          j = tbl_count;
          while (j > 0 && tbl_key[j-1] > key) begin
            tbl_key[j]   = tbl_key[j-1];
            tbl_price[j] = tbl_price[j-1];
            tbl_qty[j]   = tbl_qty[j-1];
            j--;
          end
          tbl_key[j]   = key;
          tbl_price[j] = price;
          tbl_qty[j]   = qty;
          tbl_count++;
          r.index = sti_pkg::IDX_W'(j);
          if (tbl_count > peak_fill) peak_fill = tbl_count;
        end
      end
      sti_pkg::REQ_LOOKUP: begin
        n_lookup++;
        pos = find_key(key);
        if (pos < 0) begin
          r.status = sti_pkg::ST_NOT_FOUND;
        end else begin
          n_lookup_hit++;
          r.index = sti_pkg::IDX_W'(pos);
          r.price = tbl_price[pos];
          r.qty   = tbl_qty[pos];
        end
      end
      sti_pkg::REQ_DELETE: begin
        n_delete++;
        pos = find_key(key);
        if (pos < 0) begin
          r.status = sti_pkg::ST_NOT_FOUND;
        end else begin
          n_delete_hit++;
          r.index = sti_pkg::IDX_W'(pos);
          for (j = pos; j + 1 < tbl_count; j++) begin
            tbl_key[j]   = tbl_key[j+1];
            tbl_price[j] = tbl_price[j+1];
            tbl_qty[j]   = tbl_qty[j+1];
          end
          tbl_count--;
        end
      end
      default: begin
        // spare code: result with zero index and payload, table untouched
        n_unused++;
      end
    endcase
    r.count = sti_pkg::CNT_W'(tbl_count);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // item names packed big-endian, zero padded; a few share prefixes
  function automatic logic [sti_pkg::KEY_W-1:0] hot_key(input int n);
    case (n)
      0:       return 64'h424F_4C54_0000_0000;  // bolt
      1:       return 64'h4E55_5400_0000_0000;  // nut
      2:       return 64'h5343_5245_5700_0000;  // screw
      3:       return 64'h5741_5348_4552_0000;  // washer
      4:       return 64'h4841_4D4D_4552_0000;  // hammer
      5:       return 64'h5341_5700_0000_0000;  // saw
      6:       return 64'h4452_494C_4C00_0000;  // drill
      default: return 64'h4E41_494C_5300_0000;  // nails
    endcase
  endfunction

  // mostly keys that are held or close to held ones, so searches hit
  function automatic logic [sti_pkg::KEY_W-1:0] choose_key();
    int sel;
    int idx;
    sel = $urandom_range(99);
    if (tbl_count != 0 && sel < 40) begin
      idx = $urandom_range(tbl_count - 1);
      return tbl_key[idx];
    end else if (tbl_count != 0 && sel < 50) begin
      // a neighbor of a held key, usually absent
      idx = $urandom_range(tbl_count - 1);
      return $urandom_range(1) ? tbl_key[idx] + 64'd1 : tbl_key[idx] - 64'd1;
    end else if (sel < 75) begin
      return hot_key($urandom_range(7));
    end else if (sel < 79) begin
      return $urandom_range(1) ? '1 : '0;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [sti_pkg::PRICE_W-1:0] choose_price();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 16) return '1;
    return sti_pkg::PRICE_W'($urandom);
  endfunction

  function automatic logic [sti_pkg::QTY_W-1:0] choose_qty();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 16) return '1;
    return sti_pkg::QTY_W'($urandom);
  endfunction

  // mostly short gaps, now and then one long enough to span a whole shift
  function automatic int idle_gap_cycles();
    if ($urandom_range(99) < 80) return $urandom_range(1, 4);
    return $urandom_range(5, 100);
  endfunction

  // sends one request beat and records its predicted result on acceptance
  task automatic send_request(input logic [1:0] req,
                              input logic [sti_pkg::KEY_W-1:0] key,
                              input logic [sti_pkg::PRICE_W-1:0] price,
                              input logic [sti_pkg::QTY_W-1:0] qty);
    result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0, qty, price, key};
    do @(posedge clk); while (!s_axis_tready);
    predicted = table_apply(req, key, price, qty);
    pending_results = {pending_results, predicted};
    if (idle_on && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_gap_cycles()) @(posedge clk);
    end
  endtask

  // holds the request side until every predicted result has come back
  task automatic wait_results_drained();
    if (pending_results.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // ------------------------------------------------------------------------
  // result side: random stalls, checking, watchdog
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= 30);
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch on result beat %0d: %s got 0x%0h expected 0x%0h",
             n_checked, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input logic [1:0] status, input logic [63:0] data);
    result_t got;
    result_t want;
    // struct order from msb: status, index, price, qty, count
    got = {status, data[5:0], data[29:6], data[49:30], data[56:50]};
    n_checked++;
    if (data[63:57] != '0) report_mismatch("pad bits", data[63:57], 0);
    if (pending_results.size() == 0) begin
      report_mismatch("beat with nothing pending, status", got.status, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.index != want.index) report_mismatch("index", got.index, want.index);
    if (got.price != want.price) report_mismatch("price", got.price, want.price);
    if (got.qty != want.qty) report_mismatch("quantity", got.qty, want.qty);
    if (got.count != want.count) report_mismatch("count", got.count, want.count);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tuser, m_axis_tdata);
  end

  // counts cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // searches on an empty table miss, the spare code is ignored
  task automatic test_empty_table();
    send_request(sti_pkg::REQ_LOOKUP, hot_key(0), '0, '0);
    send_request(sti_pkg::REQ_DELETE, '1, '1, '1);
    send_request(REQ_UNUSED, '1, '1, '1);
  endtask

  // key and payload extremes, unsigned ordering, duplicates, misses
  task automatic test_extremes();
    send_request(sti_pkg::REQ_INSERT, '1, '1, '1);
    send_request(sti_pkg::REQ_INSERT, '0, '0, '0);
    send_request(sti_pkg::REQ_INSERT, 64'h8000_0000_0000_0000, 24'h123456, 20'hABCDE);
    send_request(sti_pkg::REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 24'h654321, 20'h54321);
    // three copies of one name must stay in arrival order
    send_request(sti_pkg::REQ_INSERT, hot_key(0), 24'd100, 20'd1);
    send_request(sti_pkg::REQ_INSERT, hot_key(0), 24'd200, 20'd2);
    send_request(sti_pkg::REQ_INSERT, hot_key(0), 24'd300, 20'd3);
    send_request(sti_pkg::REQ_LOOKUP, '1, '0, '0);
    send_request(sti_pkg::REQ_LOOKUP, '0, '1, '1);
    send_request(sti_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0000, '0, '0);
    send_request(sti_pkg::REQ_LOOKUP, hot_key(0), '0, '0);
    send_request(sti_pkg::REQ_LOOKUP, hot_key(0) + 64'd1, '0, '0);
    send_request(sti_pkg::REQ_DELETE, hot_key(0), '0, '0);
    send_request(sti_pkg::REQ_LOOKUP, hot_key(0), '0, '0);
    send_request(sti_pkg::REQ_DELETE, hot_key(5), '0, '0);
    send_request(REQ_UNUSED, hot_key(0), '1, '1);
    send_request(sti_pkg::REQ_DELETE, '1, '0, '0);
    send_request(sti_pkg::REQ_DELETE, '0, '0, '0);
    send_request(sti_pkg::REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
  endtask

  // fill to the top, inserts refused, then removals at both ends and at random
  task automatic test_table_full();
    int k;
    wait_results_drained();
    while (tbl_count < TBL_DEPTH)
      send_request(sti_pkg::REQ_INSERT, choose_key(), choose_price(), choose_qty());
    // let the last shift finish before pushing against a full table
    wait_results_drained();
    for (k = 0; k < 3; k++)
      send_request(sti_pkg::REQ_INSERT, choose_key(), choose_price(), choose_qty());
    send_request(sti_pkg::REQ_LOOKUP, tbl_key[TBL_DEPTH-1], '0, '0);
    send_request(sti_pkg::REQ_LOOKUP, tbl_key[0], '0, '0);
    send_request(REQ_UNUSED, choose_key(), choose_price(), choose_qty());
    send_request(sti_pkg::REQ_DELETE, tbl_key[TBL_DEPTH-1], '0, '0);
    send_request(sti_pkg::REQ_INSERT, '1, '1, '1);
    send_request(sti_pkg::REQ_INSERT, '0, '0, '0);
    send_request(sti_pkg::REQ_DELETE, tbl_key[0], '0, '0);
    for (k = 0; k < 8; k++)
      send_request(sti_pkg::REQ_DELETE, tbl_key[$urandom_range(tbl_count - 1)], '0, '0);
  endtask

  // random mix in phases that fill, churn or drain the table
  task automatic test_random_mix(input int n_items);
    int i;
    int insert_pct;
    int roll;
    logic [1:0] req;
    insert_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
      end
      // one stretch with no idling on either side
      idle_on = !(i >= n_items / 3 && i < n_items / 3 + 400);
      roll = $urandom_range(99);
      if (roll < 3) begin
        req = REQ_UNUSED;
      end else begin
        roll = $urandom_range(99);
        if (roll < insert_pct) req = sti_pkg::REQ_INSERT;
        else if (roll < insert_pct + (100 - insert_pct) / 2) req = sti_pkg::REQ_LOOKUP;
        else req = sti_pkg::REQ_DELETE;
      end
      send_request(req, choose_key(), choose_price(), choose_qty());
    end
    idle_on = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_table_full();
    test_random_mix(1850);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", pending_results.size(), 0);

    $write("covered %0d inserts (%0d refused full), %0d lookups (%0d hit), ",
           n_insert, n_refused, n_lookup, n_lookup_hit);
    $display("%0d deletes (%0d hit), %0d spare codes", n_delete, n_delete_hit, n_unused);
    $display("checked %0d result beats, peak fill %0d of %0d, %0d mismatches",
             n_checked, peak_fill, TBL_DEPTH, error_count);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
